FILE: rtl/rpe_pkg.sv
// ----------------------------------------------------------------------------
// Rotary PIN entry package
// Shared constants, command codes and the structs used by the entry datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package rpe_pkg;

  localparam int MAX_DIGITS = 8;
  localparam int POS_W      = $clog2(MAX_DIGITS + 1);
  localparam int DIGIT_W    = 4;
  localparam int CMD_W      = 3;
  localparam int RIDX_W     = 3;
  localparam int COUNT_W    = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 4;

  localparam logic [DIGIT_W-1:0] DIGIT_MAX = DIGIT_W'(9);

  typedef enum logic [CMD_W-1:0] {
    CMD_RIGHT    = 3'd0,
    CMD_LEFT     = 3'd1,
    CMD_OK_SHORT = 3'd2,
    CMD_OK_LONG  = 3'd3,
    CMD_BACK     = 3'd4,
    CMD_CLEAR    = 3'd5
  } cmd_t;

  localparam logic [CFG_IDX_W-1:0] CFG_PIN_LENGTH        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_DIGITS        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DIAL_EN           = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LAST_REVERSES     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FINISH_ON_CONFIRM = 3'd4;

  typedef struct packed {
    logic [3:0] pin_length;
    logic [3:0] min_digits;
    logic       dial_en;
    logic       last_reverses;
    logic       finish_on_confirm;
  } cfg_t;

  typedef struct packed {
    logic                 handled;
    logic                 finished;
    logic [COUNT_W-1:0]   entered_count;
    logic [DIGIT_W-1:0]   spin_digit;
    logic [DIGIT_W-1:0]   read_digit;
  } result_t;

endpackage

`default_nettype wire

FILE: rtl/rpe_in_if.sv
// ----------------------------------------------------------------------------
// Rotary PIN entry event channel
// Valid/ready channel carrying one input event beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface rpe_in_if;
  logic                        valid;
  logic                        ready;
  logic [rpe_pkg::CMD_W-1:0]   command;
  logic [rpe_pkg::RIDX_W-1:0]  read_index;

  modport source (output valid, output command, output read_index, input ready);
  modport sink   (input valid, input command, input read_index, output ready);
endinterface

`default_nettype wire

FILE: rtl/rpe_out_if.sv
// ----------------------------------------------------------------------------
// Rotary PIN entry result channel
// Valid/ready channel carrying one result beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface rpe_out_if;
  logic                          valid;
  logic                          ready;
  logic                          handled;
  logic                          finished;
  logic [rpe_pkg::COUNT_W-1:0]   entered_count;
  logic [rpe_pkg::DIGIT_W-1:0]   spin_digit;
  logic [rpe_pkg::DIGIT_W-1:0]   read_digit;

  modport source (output valid, output handled, output finished, output entered_count,
                  output spin_digit, output read_digit, input ready);
  modport sink   (input valid, input handled, input finished, input entered_count,
                  input spin_digit, input read_digit, output ready);
endinterface

`default_nettype wire

FILE: rtl/rpe_engine.sv
// ----------------------------------------------------------------------------
// Rotary PIN entry engine
// Entry state, digit store and the single-pass update for one event.
// ----------------------------------------------------------------------------
`default_nettype none

module rpe_engine (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        step,
  input  wire logic [rpe_pkg::CMD_W-1:0]   cmd,
  input  wire logic [rpe_pkg::RIDX_W-1:0]  ridx,
  input  wire rpe_pkg::cfg_t               cfg,
  output rpe_pkg::result_t                 res
);

  logic [rpe_pkg::POS_W-1:0]   pos_r,   pos_nxt;
  logic [rpe_pkg::DIGIT_W-1:0] spin_r,  spin_nxt;
  logic                        eng_r,   eng_nxt;
  logic                        done_r,  done_nxt;
  logic [rpe_pkg::DIGIT_W-1:0] store_r   [rpe_pkg::MAX_DIGITS];
  logic [rpe_pkg::DIGIT_W-1:0] store_nxt [rpe_pkg::MAX_DIGITS];

  logic [rpe_pkg::POS_W-1:0]   len;
  logic [rpe_pkg::POS_W-1:0]   min_len;
  logic [rpe_pkg::POS_W-1:0]   pos_inc;
  logic [rpe_pkg::POS_W-1:0]   pos_dec;
  logic                        right;
  logic                        cw_expected;
  logic                        free_last;
  logic                        handled;
  logic                        wr_cur;
  logic                        wr_zero_next;
  logic                        wr_zero_prev;
  logic [rpe_pkg::DIGIT_W-1:0] rd_digit;

  function automatic logic [rpe_pkg::DIGIT_W-1:0] spin_step(
    input logic [rpe_pkg::DIGIT_W-1:0] val,
    input logic                        up
  );
    logic [rpe_pkg::DIGIT_W-1:0] r;
    if (up) begin
      r = (val >= rpe_pkg::DIGIT_MAX) ? '0 : val + 1'b1;
    end else begin
      r = (val == '0) ? rpe_pkg::DIGIT_MAX : val - 1'b1;
    end
    return r;
  endfunction

  always_comb begin
    if (32'(cfg.pin_length) > rpe_pkg::MAX_DIGITS) begin
      len = rpe_pkg::POS_W'(rpe_pkg::MAX_DIGITS);
    end else begin
      len = rpe_pkg::POS_W'(cfg.pin_length);
    end
    if (32'(cfg.min_digits) > 32'(len)) begin
      min_len = len;
    end else begin
      min_len = rpe_pkg::POS_W'(cfg.min_digits);
    end
  end

  assign pos_inc     = pos_r + 1'b1;
  assign pos_dec     = pos_r - 1'b1;
  assign right       = (cmd == rpe_pkg::CMD_RIGHT);
  assign cw_expected = ~pos_r[0];
  assign free_last   = (pos_inc == len) && !cfg.last_reverses;

  always_comb begin
    pos_nxt      = pos_r;
    spin_nxt     = spin_r;
    eng_nxt      = eng_r;
    done_nxt     = done_r;
    handled      = 1'b1;
    wr_cur       = 1'b0;
    wr_zero_next = 1'b0;
    wr_zero_prev = 1'b0;
    unique case (cmd)
      rpe_pkg::CMD_RIGHT, rpe_pkg::CMD_LEFT: begin
        if (!cfg.dial_en || pos_r >= len) begin
          spin_nxt = spin_step(spin_r, right);
        end else if (right == cw_expected) begin
          eng_nxt  = 1'b1;
          spin_nxt = spin_step(spin_r, right);
        end else if (free_last || !eng_r) begin
          spin_nxt = spin_step(spin_r, right);
        end else begin
          wr_cur       = 1'b1;
          wr_zero_next = 1'b1;
          pos_nxt      = pos_inc;
          if (cfg.finish_on_confirm && pos_inc >= len) begin
            done_nxt = 1'b1;
          end
          eng_nxt  = 1'b1;
          spin_nxt = right ? rpe_pkg::DIGIT_W'(1) : rpe_pkg::DIGIT_MAX;
        end
      end
      rpe_pkg::CMD_OK_SHORT: begin
        if (pos_r < len) begin
          wr_cur       = 1'b1;
          wr_zero_next = 1'b1;
          pos_nxt      = pos_inc;
          if (cfg.finish_on_confirm && pos_inc >= len) begin
            done_nxt = 1'b1;
          end
          spin_nxt = '0;
        end
      end
      rpe_pkg::CMD_OK_LONG: begin
        if (pos_r >= min_len && pos_r <= len) begin
          done_nxt = 1'b1;
        end
      end
      rpe_pkg::CMD_BACK: begin
        if (pos_r == '0) begin
          handled = 1'b0;
        end else begin
          pos_nxt      = pos_dec;
          wr_zero_prev = 1'b1;
          spin_nxt     = '0;
          eng_nxt      = 1'b0;
        end
      end
      rpe_pkg::CMD_CLEAR: begin
        pos_nxt  = '0;
        spin_nxt = '0;
        eng_nxt  = 1'b0;
        done_nxt = 1'b0;
      end
      default: begin
        handled = 1'b0;
      end
    endcase
  end

  always_comb begin
    for (int i = 0; i < rpe_pkg::MAX_DIGITS; i++) begin
      store_nxt[i] = store_r[i];
      if (cmd == rpe_pkg::CMD_CLEAR) begin
        store_nxt[i] = '0;
      end else if (wr_cur && pos_r == rpe_pkg::POS_W'(i)) begin
        store_nxt[i] = spin_r;
      end else if (wr_zero_next && pos_inc == rpe_pkg::POS_W'(i)) begin
        store_nxt[i] = '0;
      end else if (wr_zero_prev && pos_dec == rpe_pkg::POS_W'(i)) begin
        store_nxt[i] = '0;
      end
    end
  end

  always_comb begin
    rd_digit = '0;
    for (int i = 0; i < rpe_pkg::MAX_DIGITS; i++) begin
      if (32'(ridx) == i) begin
        rd_digit = store_nxt[i];
      end
    end
  end

  assign res.handled       = handled;
  assign res.finished      = done_nxt;
  assign res.entered_count = rpe_pkg::COUNT_W'(pos_nxt);
  assign res.spin_digit    = spin_nxt;
  assign res.read_digit    = rd_digit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      spin_r <= '0;
      eng_r  <= 1'b0;
      done_r <= 1'b0;
      for (int i = 0; i < rpe_pkg::MAX_DIGITS; i++) begin
        store_r[i] <= '0;
      end
    end else if (step) begin
      pos_r  <= pos_nxt;
      spin_r <= spin_nxt;
      eng_r  <= eng_nxt;
      done_r <= done_nxt;
      for (int i = 0; i < rpe_pkg::MAX_DIGITS; i++) begin
        store_r[i] <= store_nxt[i];
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/rotary_pin_entry_controller.sv
// ----------------------------------------------------------------------------
// Rotary PIN entry controller
// Builds a decimal PIN from encoder notches and button events, one result
// beat per event beat.
// ----------------------------------------------------------------------------
// Usage:
//   in_if  : event beats (command, read_index), valid/ready.
//   out_if : one result beat per event (handled, finished, entered_count,
//            spin_digit, read_digit), valid/ready.
//   cfg_*  : register write port; write only while no event is in flight.
// Datapath: an accepted event goes into the input register, then through one pass
//   of update logic into the result register.
// Throughput: one event per cycle while the result is not stalled; the entry
//   state updates once per event, so each event sees everything before it.
// Stall: while out_if.ready is low the result holds and one more event is
//   taken into the input register; then in_if.ready drops.
// Reset: registers return to their defaults (length 4, minimum 4, standard
//   mode, last digit by reversal, no finish on confirm); PIN state clears.
// ----------------------------------------------------------------------------
`default_nettype none

module rotary_pin_entry_controller (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  rpe_in_if.sink                                in_if,
  rpe_out_if.source                             out_if,
  input  wire logic                             cfg_we,
  input  wire logic [rpe_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [rpe_pkg::CFG_DATA_W-1:0]   cfg_data
);

  rpe_pkg::cfg_t              cfg_r;
  logic                       in_vld_r;
  logic [rpe_pkg::CMD_W-1:0]  in_cmd_r;
  logic [rpe_pkg::RIDX_W-1:0] in_ridx_r;
  logic                       out_vld_r;
  rpe_pkg::result_t           out_r;
  rpe_pkg::result_t           res;
  logic                       adv;
  logic                       in_rdy;
  logic                       step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pin_length        <= 4'd4;
      cfg_r.min_digits        <= 4'd4;
      cfg_r.dial_en           <= 1'b0;
      cfg_r.last_reverses     <= 1'b1;
      cfg_r.finish_on_confirm <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rpe_pkg::CFG_PIN_LENGTH:        cfg_r.pin_length        <= cfg_data;
        rpe_pkg::CFG_MIN_DIGITS:        cfg_r.min_digits        <= cfg_data;
        rpe_pkg::CFG_DIAL_EN:           cfg_r.dial_en           <= cfg_data[0];
        rpe_pkg::CFG_LAST_REVERSES:     cfg_r.last_reverses     <= cfg_data[0];
        rpe_pkg::CFG_FINISH_ON_CONFIRM: cfg_r.finish_on_confirm <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  assign adv         = !out_vld_r || out_if.ready;
  assign in_rdy      = !in_vld_r || adv;
  assign step        = in_vld_r && adv;
  assign in_if.ready = in_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_rdy) begin
      in_vld_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_rdy && in_if.valid) begin
      in_cmd_r  <= in_if.command;
      in_ridx_r <= in_if.read_index;
    end
  end

  rpe_engine u_engine (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .cmd   (in_cmd_r),
    .ridx  (in_ridx_r),
    .cfg   (cfg_r),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_r <= res;
    end
  end

  assign out_if.valid         = out_vld_r;
  assign out_if.handled       = out_r.handled;
  assign out_if.finished      = out_r.finished;
  assign out_if.entered_count = out_r.entered_count;
  assign out_if.spin_digit    = out_r.spin_digit;
  assign out_if.read_digit    = out_r.read_digit;

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (32'(out_r.entered_count) <= rpe_pkg::MAX_DIGITS))
    else $error("entered count beyond maximum length");

  a_spin_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (out_r.spin_digit <= rpe_pkg::DIGIT_MAX))
    else $error("spin digit out of decimal range");

  a_hold_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (in_vld_r && !adv) |=> (in_vld_r && $stable(in_cmd_r) && $stable(in_ridx_r)))
    else $error("pending event lost while result stalled");

  a_unhandled_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    (step && !res.handled) |-> (in_cmd_r == rpe_pkg::CMD_BACK || in_cmd_r > rpe_pkg::CMD_CLEAR))
    else $error("event dropped for a known command");

endmodule

`default_nettype wire
